>>> sv/fsrs_pkg.sv
package fsrs_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned UNITS_W  = 4;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned RES_W    = 2;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [UNITS_W-1:0] UNITS_RESET = 4'd1;

  localparam int unsigned DEF_NUM_RESOURCES = 4;
  localparam int unsigned DEF_NUM_CLIENTS   = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RETURNED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PASSED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch the incoming item
    logic exec;     // decide and update the semaphore state
    logic capture;  // take the head waiter read from the queue memory
    logic load;     // move the pending result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;  // the item passes a unit to a queued waiter
  } dp_sts_t;

endpackage

>>> sv/fsrs_ram.sv
module fsrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fsrs_ctrl.sv
module fsrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fsrs_pkg::dp_sts_t sts_i,
  output fsrs_pkg::dp_cmd_t cmd_o
);
  import fsrs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_read ? S_READ : S_LOAD;
      end
      S_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/fsrs_dp.sv
module fsrs_dp #(
  parameter int unsigned NUM_RESOURCES = fsrs_pkg::DEF_NUM_RESOURCES,
  parameter int unsigned NUM_CLIENTS   = fsrs_pkg::DEF_NUM_CLIENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsrs_pkg::UNITS_W-1:0]  cfg_wdata_i,
  input  logic [fsrs_pkg::CMD_W-1:0]    cmd_i,
  input  logic [fsrs_pkg::REQ_W-1:0]    requester_i,
  input  logic [fsrs_pkg::RES_W-1:0]    resource_i,
  input  fsrs_pkg::dp_cmd_t             ctl_i,
  output fsrs_pkg::dp_sts_t             sts_o,
  output logic [fsrs_pkg::STATUS_W-1:0] status_o,
  output logic [fsrs_pkg::REQ_W-1:0]    grant_id_o,
  output logic                          grant_valid_o
);
  import fsrs_pkg::*;

  localparam int unsigned RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int unsigned CIDX_W = $clog2(NUM_CLIENTS);
  localparam int unsigned RV_W   = $clog2(NUM_RESOURCES + 1);
  localparam int unsigned CNT_W  = $clog2(NUM_CLIENTS + 1);
  localparam int unsigned QDEPTH = NUM_RESOURCES * NUM_CLIENTS;
  localparam int unsigned QA_W   = $clog2(QDEPTH);
  localparam logic [RV_W-1:0] RESV_NONE = RV_W'(NUM_RESOURCES);

  // Latched item.
  logic [CMD_W-1:0] cmd_q;
  logic [REQ_W-1:0] req_q;
  logic [RES_W-1:0] res_q;

  // Semaphore state.
  logic [UNITS_W-1:0] units_q;
  logic [UNITS_W-1:0] free_q [NUM_RESOURCES];
  logic [RV_W-1:0]    resv_q [NUM_CLIENTS];
  logic [CNT_W-1:0]   cnt_q  [NUM_RESOURCES];
  logic [CIDX_W-1:0]  head_q [NUM_RESOURCES];
  logic [CIDX_W-1:0]  tail_q [NUM_RESOURCES];

  // Pending and output results.
  logic [STATUS_W-1:0] pst_q, pst_d;
  logic [REQ_W-1:0]    pgid_q, pgid_d;
  logic                pgv_q, pgv_d;
  logic [STATUS_W-1:0] ost_q;
  logic [REQ_W-1:0]    ogid_q;
  logic                ogv_q;

  logic [RIDX_W-1:0] r_idx;
  logic [CIDX_W-1:0] c_idx;
  logic              in_range;
  logic [UNITS_W-1:0] cur_free;
  logic [CNT_W-1:0]   cur_cnt;
  logic [CIDX_W-1:0]  cur_head, cur_tail, head_nxt, tail_nxt;
  logic [QA_W-1:0]    q_base;
  logic [REQ_W-1:0]   q_rdata;

  logic do_use_resv, do_take, do_enq, do_set_resv, do_pass, do_ret, do_sat;

  assign r_idx    = RIDX_W'(res_q);
  assign c_idx    = CIDX_W'(req_q);
  assign in_range = (32'(req_q) < 32'(NUM_CLIENTS)) && (32'(res_q) < 32'(NUM_RESOURCES));
  assign cur_free = free_q[r_idx];
  assign cur_cnt  = cnt_q[r_idx];
  assign cur_head = head_q[r_idx];
  assign cur_tail = tail_q[r_idx];
  assign head_nxt = (32'(cur_head) + 1 >= 32'(NUM_CLIENTS)) ? '0 : cur_head + 1'b1;
  assign tail_nxt = (32'(cur_tail) + 1 >= 32'(NUM_CLIENTS)) ? '0 : cur_tail + 1'b1;
  assign q_base   = QA_W'(QA_W'(r_idx) * QA_W'(NUM_CLIENTS));

  // Decision for the latched item.
  always_comb begin
    do_use_resv = 1'b0;
    do_take     = 1'b0;
    do_enq      = 1'b0;
    do_set_resv = 1'b0;
    do_pass     = 1'b0;
    do_ret      = 1'b0;
    do_sat      = 1'b0;
    pst_d       = ST_ERROR;
    pgid_d      = '0;
    pgv_d       = 1'b0;
    if (in_range) begin
      case (cmd_q)
        CMD_ACQUIRE: begin
          if (resv_q[c_idx] == RV_W'(r_idx)) begin
            do_use_resv = 1'b1;
            pst_d       = ST_GRANTED;
          end else if (cur_free != '0) begin
            do_take = 1'b1;
            pst_d   = ST_GRANTED;
          end else if (32'(cur_cnt) < 32'(NUM_CLIENTS)) begin
            do_enq = 1'b1;
            pst_d  = ST_QUEUED;
          end
          if (pst_d == ST_GRANTED) begin
            pgid_d = req_q;
            pgv_d  = 1'b1;
          end
        end
        CMD_RESERVE: begin
          if (cur_free != '0 && resv_q[c_idx] >= RESV_NONE) begin
            do_set_resv = 1'b1;
            pst_d       = ST_RESERVED;
          end else begin
            pst_d = ST_REFUSED;
          end
        end
        CMD_RELEASE: begin
          if (cur_cnt != '0) begin
            do_pass = 1'b1;
            pgv_d   = 1'b1;
            pst_d   = ST_PASSED;
          end else if (cur_free < units_q) begin
            do_ret = 1'b1;
            pst_d  = ST_RETURNED;
          end else begin
            do_sat = 1'b1;
          end
        end
        default: pst_d = ST_ERROR;
      endcase
    end
  end

  assign sts_o.need_read = do_pass;

  fsrs_ram #(
    .WIDTH (REQ_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ctl_i.exec && do_enq),
    .waddr_i (QA_W'(q_base + QA_W'(cur_tail))),
    .wdata_i (req_q),
    .raddr_i (QA_W'(q_base + QA_W'(cur_head))),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q <= cmd_i;
      req_q <= requester_i;
      res_q <= resource_i;
    end
    if (ctl_i.exec) begin
      pst_q  <= pst_d;
      pgid_q <= pgid_d;
      pgv_q  <= pgv_d;
    end else if (ctl_i.capture) begin
      pgid_q <= q_rdata;
    end
    if (ctl_i.load) begin
      ost_q  <= pst_q;
      ogid_q <= pgid_q;
      ogv_q  <= pgv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      units_q <= UNITS_RESET;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        free_q[i] <= UNITS_RESET;
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        resv_q[i] <= RESV_NONE;
      end
    end else if (cfg_we_i) begin
      units_q <= cfg_wdata_i;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        free_q[i] <= cfg_wdata_i;
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        resv_q[i] <= RESV_NONE;
      end
    end else if (ctl_i.exec) begin
      if (do_use_resv) begin
        resv_q[c_idx] <= RESV_NONE;
      end
      if (do_take) begin
        free_q[r_idx] <= cur_free - 1'b1;
      end
      if (do_enq) begin
        tail_q[r_idx] <= tail_nxt;
        cnt_q[r_idx]  <= cur_cnt + 1'b1;
      end
      if (do_set_resv) begin
        resv_q[c_idx] <= RV_W'(r_idx);
        free_q[r_idx] <= cur_free - 1'b1;
      end
      if (do_pass) begin
        head_q[r_idx] <= head_nxt;
        cnt_q[r_idx]  <= cur_cnt - 1'b1;
      end
      if (do_ret) begin
        free_q[r_idx] <= cur_free + 1'b1;
      end
      if (do_sat) begin
        free_q[r_idx] <= units_q;
      end
    end
  end

  assign status_o      = ost_q;
  assign grant_id_o    = ogid_q;
  assign grant_valid_o = ogv_q;

endmodule

>>> sv/fifo_resource_semaphore_with_reservation_top.sv
// Counting semaphore bank with a FIFO wait queue per resource and one-shot
// reservations per client.
//
// Each transfer on the input channel (in_valid_i / in_ready_o) carries a
// command, a requester and a resource; each one produces exactly one
// transfer on the output channel (out_valid_o / out_ready_i) with a status,
// a grant id and a grant flag. Items are handled one at a time by a small
// sequencer: after the input transfer the item is decided and the state is
// updated in the execute state, and its result then enters the output
// register in the load state, after which out_valid_o rises. A release that
// passes its unit to a queued client goes through an extra read state,
// because the waiter's id comes from the wait-queue memory, whose read data
// is registered. No new item is taken until the last result is loaded.
// The input side reopens while a result still waits in the output
// register; if the receiver stalls, the next result waits inside the
// block until the output register is taken. Reset (rst_ni, asynchronous,
// active low) sets the unit count to one, fills every pool, empties every
// queue and drops every reservation. Writing the unit count through
// cfg_we_i does the same with the new count and must only happen while idle.
module fifo_resource_semaphore_with_reservation_top #(
  parameter int unsigned NUM_RESOURCES = fsrs_pkg::DEF_NUM_RESOURCES,
  parameter int unsigned NUM_CLIENTS   = fsrs_pkg::DEF_NUM_CLIENTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsrs_pkg::UNITS_W-1:0]  cfg_units_per_resource_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fsrs_pkg::CMD_W-1:0]    cmd_i,
  input  logic [fsrs_pkg::REQ_W-1:0]    requester_i,
  input  logic [fsrs_pkg::RES_W-1:0]    resource_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fsrs_pkg::STATUS_W-1:0] status_o,
  output logic [fsrs_pkg::REQ_W-1:0]    grant_id_o,
  output logic                          grant_valid_o
);
  import fsrs_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  // The controller sequences one item through accept, execute, optional
  // queue read and output load.
  fsrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (ctl)
  );

  // The datapath holds the pools, reservations, queue pointers, the queue
  // memory and the result registers.
  fsrs_dp #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .NUM_CLIENTS   (NUM_CLIENTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_units_per_resource_i),
    .cmd_i         (cmd_i),
    .requester_i   (requester_i),
    .resource_i    (resource_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .status_o      (status_o),
    .grant_id_o    (grant_id_o),
    .grant_valid_o (grant_valid_o)
  );

endmodule

>>> sv/fsrs_checker.sv
module fsrs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [fsrs_pkg::STATUS_W-1:0] status_o,
  input logic [fsrs_pkg::REQ_W-1:0]    grant_id_o,
  input logic                          grant_valid_o
);
  import fsrs_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(grant_id_o) && $stable(grant_valid_o))
    else $error("stalled result changed");

  // The grant flag matches the status code.
  a_gv_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (grant_valid_o == (status_o == ST_GRANTED || status_o == ST_PASSED)))
    else $error("grant flag does not match status");

  // No client is named without a grant.
  a_gid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !grant_valid_o |-> grant_id_o == '0)
    else $error("grant id set without grant");

  // One item at a time: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input reopened during an item");

endmodule

bind fifo_resource_semaphore_with_reservation_top fsrs_checker u_fsrs_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps

// Testbench for the counting semaphore bank. A queue of pending commands feeds
// a driver that offers them on the input channel; every input transfer is run
// through a local copy of the semaphore state, and the outcome it gives is
// queued. A monitor compares each output transfer against the oldest queued
// outcome. The unit count is rewritten between phases, only while the block
// is idle, and the idling of both channels changes from phase to phase.
module tb;
  import fsrs_pkg::*;

  localparam int unsigned NR = DEF_NUM_RESOURCES;
  localparam int unsigned NC = DEF_NUM_CLIENTS;

  // The block knows three commands; the fourth code must be flagged as an error.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // A reservation entry that holds the resource count means the client has none.
  localparam logic [2:0] NO_RESV = 3'd4;

  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 215;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] req;
    logic [RES_W-1:0] res;
  } sem_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REQ_W-1:0]    grant_id;
    logic                grant_valid;
  } sem_result_t;

  // Block ports. Every input starts at a known value.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [UNITS_W-1:0]  cfg_units_per_resource_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i = '0;
  logic [REQ_W-1:0]    requester_i = '0;
  logic [RES_W-1:0]    resource_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [REQ_W-1:0]    grant_id_o;
  logic                grant_valid_o;

  // Local copy of the semaphore state and of the unit count.
  logic [UNITS_W-1:0] unit_cfg;
  logic [3:0]         pool_free [NR];
  logic [2:0]         held_resv [NC];
  logic [3:0]         q_len     [NR];
  logic [REQ_W-1:0]   q_mem     [NR][NC];
  logic [2:0]         q_rd      [NR];
  logic [2:0]         q_wr      [NR];

  // Commands still to be offered, and outcomes still to be seen on the output.
  sem_item_t   cmd_backlog[$];
  sem_result_t want_results[$];

  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // The receiver's long hold-off is counted down in a process of its own.
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;

  // Set when the offered command has been transferred, so that the driver
  // knows it may move on to the next one.
  logic        in_taken = 1'b0;

  sem_item_t   drv_item;
  sem_result_t mon_got;
  sem_result_t mon_want;

  fifo_resource_semaphore_with_reservation_top #(
    .NUM_RESOURCES(NR),
    .NUM_CLIENTS  (NC)
  ) u_top (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_units_per_resource_i(cfg_units_per_resource_i),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .cmd_i                   (cmd_i),
    .requester_i             (requester_i),
    .resource_i              (resource_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .status_o                (status_o),
    .grant_id_o              (grant_id_o),
    .grant_valid_o           (grant_valid_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Fill every pool with the current unit count, empty the queues and drop
  // all reservations. The queue memory keeps its contents, as in the block.
  function automatic void sem_reload();
    for (int r = 0; r < NR; r++) begin
      pool_free[r] = unit_cfg;
      q_len[r]     = '0;
      q_rd[r]      = '0;
      q_wr[r]      = '0;
    end
    for (int c = 0; c < NC; c++) begin
      held_resv[c] = NO_RESV;
    end
  endfunction

  // Decide one command against the local state and update it; the return
  // value is the outcome the block must report for it.
  function automatic sem_result_t sem_decide(sem_item_t it);
    sem_result_t rsp;
    int unsigned c;
    int unsigned r;
    rsp.status      = ST_ERROR;
    rsp.grant_id    = '0;
    rsp.grant_valid = 1'b0;
    c = 32'(it.req);
    r = 32'(it.res);
    case (it.cmd)
      CMD_ACQUIRE: begin
        // A reservation on this resource is used up first, then a free unit;
        // otherwise the client waits at the tail, unless the queue is full.
        if (held_resv[c] == r) begin
          held_resv[c] = NO_RESV;
          rsp.status   = ST_GRANTED;
        end else if (pool_free[r] != 0) begin
          pool_free[r] = pool_free[r] - 1'b1;
          rsp.status   = ST_GRANTED;
        end else if (q_len[r] < NC) begin
          q_mem[r][q_wr[r]] = it.req;
          q_wr[r]  = (q_wr[r] == NC - 1) ? 3'd0 : q_wr[r] + 1'b1;
          q_len[r] = q_len[r] + 1'b1;
          rsp.status = ST_QUEUED;
        end
        if (rsp.status == ST_GRANTED) begin
          rsp.grant_id    = it.req;
          rsp.grant_valid = 1'b1;
        end
      end
      CMD_RESERVE: begin
        // A client may hold only one reservation at a time.
        if (pool_free[r] != 0 && held_resv[c] >= NR) begin
          held_resv[c] = 3'(r);
          pool_free[r] = pool_free[r] - 1'b1;
          rsp.status   = ST_RESERVED;
        end else begin
          rsp.status = ST_REFUSED;
        end
      end
      CMD_RELEASE: begin
        if (q_len[r] != 0) begin
          rsp.grant_id    = q_mem[r][q_rd[r]];
          rsp.grant_valid = 1'b1;
          rsp.status      = ST_PASSED;
          q_rd[r]  = (q_rd[r] == NC - 1) ? 3'd0 : q_rd[r] + 1'b1;
          q_len[r] = q_len[r] - 1'b1;
        end else if (pool_free[r] < unit_cfg) begin
          pool_free[r] = pool_free[r] + 1'b1;
          rsp.status   = ST_RETURNED;
        end else begin
          // The pool is already full: it stays saturated and the release
          // is reported as an error.
          pool_free[r] = unit_cfg;
          rsp.status   = ST_ERROR;
        end
      end
      default: begin
        rsp.status = ST_ERROR;
      end
    endcase
    return rsp;
  endfunction

  task automatic push_item(input logic [CMD_W-1:0] cmd, input int unsigned req,
                           input int unsigned res);
    sem_item_t it;
    it.cmd = cmd;
    it.req = REQ_W'(req);
    it.res = RES_W'(res);
    cmd_backlog.push_back(it);
  endtask

  // Wait until every command has been transferred and every outcome has
  // come back, then let the block settle.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_valid_i || want_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input side: each transfer is decided at once against the local state.
  // Commands are handled strictly in order, so the outcomes queue up in the
  // order in which they must come out.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      want_results.push_back(sem_decide({cmd_i, requester_i, resource_i}));
      in_taken = 1'b1;
    end
  end

  // Driver: a command that is offered stays on the port until it is
  // transferred. Only then may the next one be offered, after a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = cmd_backlog.pop_front();
        in_valid_i  <= 1'b1;
        cmd_i       <= drv_item.cmd;
        requester_i <= drv_item.req;
        resource_i  <= drv_item.res;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Countdown of the long receiver hold-off.
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stalls at random, and not at all-ready during the hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: every output transfer must match the oldest waiting outcome.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mon_got = {status_o, grant_id_o, grant_valid_o};
      if (want_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d id %0d valid %0b",
                 $time, mon_got.status, mon_got.grant_id, mon_got.grant_valid);
        err_count++;
      end else begin
        mon_want = want_results.pop_front();
        if (mon_got !== mon_want) begin
          $display("%0t: result mismatch: expected status %0d id %0d valid %0b, actual status %0d id %0d valid %0b",
                   $time, mon_want.status, mon_want.grant_id, mon_want.grant_valid,
                   mon_got.status, mon_got.grant_id, mon_got.grant_valid);
          err_count++;
        end
      end
    end
  end

  initial begin
    int unsigned units;
    int unsigned hot;
    int unsigned roll;
    sem_item_t   it;

    unit_cfg = UNITS_RESET;
    sem_reload();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset unit count of one.
    push_item(CMD_ACQUIRE, 0, 0);  // granted, the pool is now empty
    push_item(CMD_ACQUIRE, 1, 0);  // queued
    push_item(CMD_RESERVE, 2, 0);  // refused, nothing free
    push_item(CMD_RELEASE, 0, 0);  // passed to client 1
    push_item(CMD_RELEASE, 1, 0);  // returned to the pool
    push_item(CMD_RELEASE, 1, 0);  // pool overflow
    push_item(CMD_RESERVE, 2, 1);  // reserved
    push_item(CMD_RESERVE, 2, 2);  // refused, a reservation is already held
    push_item(CMD_ACQUIRE, 2, 1);  // granted through the reservation
    push_item(CMD_ACQUIRE, 3, 1);  // queued
    push_item(CMD_RELEASE, 7, 1);  // passed to client 3
    push_item(CMD_UNKNOWN, 7, 3);  // unknown command
    push_item(CMD_ACQUIRE, 7, 3);  // granted
    for (int c = 0; c < NC; c++) begin
      push_item(CMD_ACQUIRE, c, 3);  // fills the queue of resource 3
    end
    push_item(CMD_ACQUIRE, 5, 3);  // queue full
    push_item(CMD_RELEASE, 0, 3);  // passed to the head waiter
    push_item(CMD_ACQUIRE, 6, 3);  // queued, the tail wraps around
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       units = 15;
        1:       units = 0;
        2:       units = 1;
        3:       units = 2;
        4:       units = $urandom_range(14, 3);
        5:       units = 15;
        6:       units = 0;
        default: units = $urandom_range(15, 1);
      endcase

      // The block is idle here, so the unit count may be rewritten.
      @(negedge clk_i);
      cfg_units_per_resource_i = UNITS_W'(units);
      cfg_we_i = 1'b1;
      unit_cfg = UNITS_W'(units);
      sem_reload();
      @(negedge clk_i);
      cfg_we_i = 1'b0;

      // Idling modes: none, sender idle, receiver stalling, both.
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase

      // In the first random phase the receiver holds off for a long stretch
      // while the sender keeps offering, so the block backs up to its input.
      if (p == 0) begin
        hold_start = 1'b1;
        @(negedge clk_i);
        hold_start = 1'b0;
      end

      // Most commands address one busy resource, so that its pool drains,
      // its queue fills up and overflows, and units are handed to waiters.
      hot = $urandom_range(NR - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          it.cmd = CMD_ACQUIRE;
        end else if (roll < 62) begin
          it.cmd = CMD_RESERVE;
        end else if (roll < 96) begin
          it.cmd = CMD_RELEASE;
        end else begin
          it.cmd = CMD_UNKNOWN;
        end
        it.req = REQ_W'($urandom_range(NC - 1));
        it.res = ($urandom_range(9) < 6) ? RES_W'(hot) : RES_W'($urandom_range(NR - 1));
        cmd_backlog.push_back(it);
      end

      // The sender pauses here until every outcome has come back.
      wait_idle();
    end

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hang; the normal run takes a small fraction of this.
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
